// File: sv/agh_pkg.sv
// shared types and constants of the alpha/gradient log histogram
// no dependencies
package agh_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int IDX_W       = 8;
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int LOG_FRAC    = 16;
    localparam int LOG_W       = 5 + LOG_FRAC;
    localparam int SUM_W       = 18;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [IDX_W-1:0]       IDX_MAX   = {IDX_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              op;
        logic [ADDR_W-1:0] addr;
    } t_qentry;

endpackage

// File: sv/agh_front.sv
// front end: takes commands, works out the bin address of a voxel
// depends on agh_pkg
module agh_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_command,
    input  logic [7:0]               i_red,
    input  logic [7:0]               i_green,
    input  logic [7:0]               i_blue,
    input  logic [7:0]               i_alpha,
    input  logic [7:0]               i_read_row,
    input  logic [7:0]               i_read_col,
    output logic                     o_push,
    output agh_pkg::t_qentry         o_entry,
    input  logic                     i_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SQRT = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                         r_state;
    agh_pkg::t_cmd                   r_op;
    logic [agh_pkg::IDX_W-1:0]       r_row;
    logic [agh_pkg::IDX_W-1:0]       r_col;
    logic [agh_pkg::SUM_W-1:0]       r_rem;
    logic [agh_pkg::SUM_W:0]         r_res;
    logic [agh_pkg::SUM_W-2:0]       r_bit;
    logic [3:0]                      r_cnt;

    logic                            acc;
    logic [agh_pkg::SUM_W-1:0]       sum;
    logic [agh_pkg::SUM_W:0]         n_sum;
    logic                            ge;
    logic [agh_pkg::SUM_W:0]         n_res;

    function automatic logic [agh_pkg::SUM_W-1:0] sq(input logic [7:0] c);
        logic signed [9:0]  t;
        logic signed [19:0] p;
        t = $signed({1'b0, c, 1'b0}) - 10'sd255;
        p = t * t;
        return {2'b00, p[15:0]};
    endfunction

    assign acc   = i_valid && (r_state == F_IDLE);
    assign sum   = sq(i_red) + sq(i_green) + sq(i_blue);
    assign n_sum = r_res + {2'b00, r_bit};
    assign ge    = {1'b0, r_rem} >= n_sum;
    assign n_res = ge ? ((r_res >> 1) + {2'b00, r_bit}) : (r_res >> 1);

    assign o_stall = (r_state != F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_entry = '{op: r_op, addr: {r_row, r_col}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (acc) begin
                        unique case (agh_pkg::t_cmd'(i_command))
                            agh_pkg::CMD_ADD: begin
                                if (i_alpha != '0) begin
                                    r_state <= F_SQRT;
                                end
                            end
                            agh_pkg::CMD_CLEAR: r_state <= F_PUSH;
                            agh_pkg::CMD_READ:  r_state <= F_PUSH;
                            default:            r_state <= F_IDLE;
                        endcase
                    end
                end
                F_SQRT: begin
                    if (r_cnt == 4'd8) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op  <= agh_pkg::t_cmd'(i_command);
            r_row <= (agh_pkg::t_cmd'(i_command) == agh_pkg::CMD_READ) ? i_read_row : i_alpha;
            r_col <= i_read_col;
            r_rem <= sum;
            r_res <= '0;
            r_bit <= {1'b1, {(agh_pkg::SUM_W-2){1'b0}}};
            r_cnt <= '0;
        end else if (r_state == F_SQRT) begin
            if (ge) begin
                r_rem <= r_rem - n_sum[agh_pkg::SUM_W-1:0];
            end
            r_res <= n_res;
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'd8) begin
                r_col <= (n_res > {{(agh_pkg::SUM_W-agh_pkg::IDX_W+1){1'b0}}, agh_pkg::IDX_MAX})
                         ? agh_pkg::IDX_MAX : n_res[agh_pkg::IDX_W-1:0];
            end
        end
    end

endmodule

// File: sv/agh_fifo.sv
// two-entry queue between front and back end
// depends on agh_pkg
module agh_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  agh_pkg::t_qentry i_data,
    output logic             o_full,
    input  logic             i_pop,
    output agh_pkg::t_qentry o_data,
    output logic             o_empty
);

    agh_pkg::t_qentry r_mem [0:1];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: sv/agh_log.sv
// iterative fixed-point log2 unit, 16 fraction bits by repeated squaring
// depends on agh_pkg
module agh_log (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [agh_pkg::COUNT_WIDTH:0] i_value,
    output logic                       o_done,
    output logic [agh_pkg::LOG_W-1:0]  o_log
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_NORM = 4'b0010,
        L_MUL  = 4'b0100,
        L_FIX  = 4'b1000
    } t_lstate;

    t_lstate                          r_state;
    logic [31:0]                      r_m;
    logic [63:0]                      r_prod;
    logic [4:0]                       r_n;
    logic [agh_pkg::LOG_FRAC-1:0]     r_frac;
    logic [3:0]                       r_cnt;
    logic                             r_done;
    logic [32:0]                      t;

    assign t      = r_prod[63:31];
    assign o_done = r_done;
    assign o_log  = {r_n, r_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: if (i_start) r_state <= L_NORM;
                L_NORM: if (r_m[31]) r_state <= L_MUL;
                L_MUL:  r_state <= L_FIX;
                L_FIX: begin
                    if (r_cnt == 4'd15) begin
                        r_state <= L_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= L_MUL;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            L_IDLE: begin
                r_m    <= {{(31-agh_pkg::COUNT_WIDTH){1'b0}}, i_value};
                r_n    <= 5'd31;
                r_frac <= '0;
                r_cnt  <= '0;
            end
            L_NORM: begin
                if (!r_m[31]) begin
                    r_m <= r_m << 1;
                    r_n <= r_n - 5'd1;
                end
            end
            L_MUL: r_prod <= r_m * r_m;
            L_FIX: begin
                r_frac <= {r_frac[agh_pkg::LOG_FRAC-2:0], t[32]};
                r_m    <= t[32] ? t[32:1] : t[31:0];
                r_cnt  <= r_cnt + 4'd1;
            end
            default: r_cnt <= '0;
        endcase
    end

endmodule

// File: sv/agh_back.sv
// back end: bin store, peak register, luminance and result register
// depends on agh_pkg and agh_log
module agh_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  agh_pkg::t_qentry              i_entry,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [agh_pkg::COUNT_WIDTH-1:0] o_bin_count,
    output logic [agh_pkg::COUNT_WIDTH-1:0] o_peak_count,
    output logic [7:0]                    o_luminance
);

    typedef enum logic [8:0] {
        B_CLEAR = 9'b000000001,
        B_IDLE  = 9'b000000010,
        B_RD    = 9'b000000100,
        B_ADD   = 9'b000001000,
        B_RDATA = 9'b000010000,
        B_LOGC  = 9'b000100000,
        B_LOGP  = 9'b001000000,
        B_DIV   = 9'b010000000,
        B_OUT   = 9'b100000000
    } t_bstate;

    localparam int CW = agh_pkg::COUNT_WIDTH;
    localparam int NW = agh_pkg::LOG_W + 8;

    t_bstate                     r_state;
    agh_pkg::t_cmd               r_op;
    logic [agh_pkg::ADDR_W-1:0]  r_addr;
    logic [CW-1:0]               mem [0:(1 << agh_pkg::ADDR_W)-1];
    logic [CW-1:0]               r_rdata;
    logic [CW-1:0]               r_peak;
    logic [CW-1:0]               r_count;
    logic [agh_pkg::LOG_W-1:0]   r_lc;
    logic [agh_pkg::LOG_W-1:0]   r_lp;
    logic [NW-1:0]               r_num;
    logic [agh_pkg::LOG_W-1:0]   r_rem;
    logic [4:0]                  r_cnt;
    logic [7:0]                  r_lum;
    logic                        r_ovalid;
    logic [CW-1:0]               r_obin;
    logic [CW-1:0]               r_opeak;
    logic [7:0]                  r_olum;

    logic                        we;
    logic [CW-1:0]               inc;
    logic                        log_start;
    logic [CW:0]                 log_value;
    logic                        log_done;
    logic [agh_pkg::LOG_W-1:0]   log_res;
    logic [agh_pkg::LOG_W:0]     rem2;
    logic [agh_pkg::LOG_W:0]     rdiff;
    logic                        dge;
    logic [NW-1:0]               q;
    logic                        load;

    agh_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_value (log_value),
        .o_done  (log_done),
        .o_log   (log_res)
    );

    assign o_pop     = (r_state == B_IDLE) && !i_empty;
    assign we        = (r_state == B_CLEAR) || (r_state == B_ADD);
    assign inc       = (r_rdata == agh_pkg::COUNT_MAX) ? r_rdata : r_rdata + 1'b1;
    assign log_start = ((r_state == B_RDATA) && (r_rdata != '0))
                       || ((r_state == B_LOGC) && log_done);
    assign log_value = (r_state == B_RDATA) ? ({1'b0, r_rdata} + 1'b1)
                                            : ({1'b0, r_peak} + 1'b1);
    assign rem2      = {r_rem, r_num[NW-1]};
    assign rdiff     = rem2 - {1'b0, r_lp};
    assign dge       = rem2 >= {1'b0, r_lp};
    assign q         = {r_num[NW-2:0], dge};
    assign load      = (r_state == B_OUT) && (!r_ovalid || !i_stall);

    assign o_valid      = r_ovalid;
    assign o_bin_count  = r_obin;
    assign o_peak_count = r_opeak;
    assign o_luminance  = r_olum;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_addr] <= (r_state == B_CLEAR) ? '0 : inc;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_addr   <= '0;
            r_peak   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= load ? 1'b1 : (r_ovalid && i_stall);
            unique case (r_state)
                B_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == '1) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_op   <= i_entry.op;
                        r_addr <= (i_entry.op == agh_pkg::CMD_CLEAR) ? '0 : i_entry.addr;
                        if (i_entry.op == agh_pkg::CMD_CLEAR) begin
                            r_peak  <= '0;
                            r_state <= B_CLEAR;
                        end else begin
                            r_state <= B_RD;
                        end
                    end
                end
                B_RD: r_state <= (r_op == agh_pkg::CMD_ADD) ? B_ADD : B_RDATA;
                B_ADD: begin
                    if (inc > r_peak) begin
                        r_peak <= inc;
                    end
                    r_state <= B_IDLE;
                end
                B_RDATA: begin
                    r_count <= r_rdata;
                    r_lum   <= '0;
                    r_state <= (r_rdata == '0) ? B_OUT : B_LOGC;
                end
                B_LOGC: begin
                    if (log_done) begin
                        r_lc    <= log_res;
                        r_state <= B_LOGP;
                    end
                end
                B_LOGP: begin
                    if (log_done) begin
                        r_lp  <= log_res;
                        r_num <= {r_lc, 8'd0} - {8'd0, r_lc};
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_state <= (log_res == '0) ? B_OUT : B_DIV;
                    end
                end
                B_DIV: begin
                    r_rem <= dge ? rdiff[agh_pkg::LOG_W-1:0] : rem2[agh_pkg::LOG_W-1:0];
                    r_num <= q;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(NW - 1)) begin
                        r_lum   <= (q > NW'(255)) ? 8'hff : q[7:0];
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (load) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_obin  <= r_count;
            r_opeak <= r_peak;
            r_olum  <= r_lum;
        end
    end

endmodule

// File: sv/alpha_gradient_log_histogram.sv
// top level of the alpha/gradient log histogram
// depends on agh_pkg, agh_front, agh_fifo, agh_back
// In the front end an add runs the nine-step integer square root of the
// gradient magnitude; in the back end it reads, modifies and writes one bin.
// A read of a non-empty bin gives its result after two passes of the log2
// unit (7 to 30 normalising shifts plus sixteen square-and-fix steps each)
// and a 29-step divider; an empty bin skips the log2 unit and the divider.
// A clear, and reset, sweep the 65536-entry bin store one bin a cycle, so
// the back end takes no command until the sweep ends; up to two commands
// queue meanwhile before transfers stall.
module alpha_gradient_log_histogram (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_alpha,
    input  logic [7:0]  i_read_row,
    input  logic [7:0]  i_read_col,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_bin_count,
    output logic [23:0] o_peak_count,
    output logic [7:0]  o_luminance
);

    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    agh_pkg::t_qentry f_entry;
    agh_pkg::t_qentry b_entry;

    agh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_command  (i_command),
        .i_red      (i_red),
        .i_green    (i_green),
        .i_blue     (i_blue),
        .i_alpha    (i_alpha),
        .i_read_row (i_read_row),
        .i_read_col (i_read_col),
        .o_push     (push),
        .o_entry    (f_entry),
        .i_full     (full)
    );

    agh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (b_entry),
        .o_empty (empty)
    );

    agh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_entry      (b_entry),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_bin_count  (o_bin_count),
        .o_peak_count (o_peak_count),
        .o_luminance  (o_luminance)
    );

endmodule

// File: sv/agh_checker.sv
// port-level checks for the alpha/gradient log histogram
// depends on alpha_gradient_log_histogram, bound to it below
module agh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [23:0] o_bin_count,
    input logic [23:0] o_peak_count,
    input logic [7:0]  o_luminance
);

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_bin_count) && $stable(o_luminance))
        else $error("stalled result changed");

    a_empty_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_bin_count == '0) |-> (o_luminance == '0))
        else $error("empty bin with nonzero luminance");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bin_count <= o_peak_count))
        else $error("bin count above peak");

endmodule

bind alpha_gradient_log_histogram agh_checker u_agh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_bin_count  (o_bin_count),
    .o_peak_count (o_peak_count),
    .o_luminance  (o_luminance)
);

// File: verif/tb_alpha_gradient_log_histogram.sv
// self-checking testbench of the alpha/gradient log histogram
// depends on agh_pkg and alpha_gradient_log_histogram; predicts reads with a local model
`timescale 1ns / 100ps

module tb_alpha_gradient_log_histogram;

    localparam int N_RANDOM   = 750;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        agh_pkg::t_cmd op;
        logic [7:0] r, g, b, a, row, col;
        bit         known;
        logic [23:0] cnt, pk;
        logic [7:0] lum;
    } t_stim;

    typedef struct {
        logic [23:0] cnt, pk;
        logic [7:0]  lum;
    } t_bin_read;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = agh_pkg::CMD_NONE;
    logic [7:0]  i_red = '0, i_green = '0, i_blue = '0, i_alpha = '0;
    logic [7:0]  i_read_row = '0, i_read_col = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [23:0] o_bin_count, o_peak_count;
    logic [7:0]  o_luminance;

    logic [23:0] hist [0:65535];
    logic [23:0] peak;
    t_bin_read   pending_reads [$];
    int          errors = 0;
    int          cycles = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;

    alpha_gradient_log_histogram DUT (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [7:0] grad_col(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int s, q;
        s = (2 * r - 255) * (2 * r - 255) + (2 * g - 255) * (2 * g - 255)
            + (2 * b - 255) * (2 * b - 255);
        q = 0;
        while ((q + 1) * (q + 1) <= s) q++;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic longint unsigned fixed_log2(longint unsigned v);
        int n;
        longint unsigned m, f;
        n = 0;
        f = 0;
        while (n < 63 && (v >> (n + 1)) != 0) n++;
        m = (n <= 31) ? (v << (31 - n)) : (v >> (n - 31));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            f = f << 1;
            if (m >= (64'd2 << 31)) begin
                f = f | 1;
                m = m >> 1;
            end
        end
        return (longint'(n) << 16) | f;
    endfunction

    function automatic t_bin_read read_bin(logic [7:0] row, logic [7:0] col);
        t_bin_read res;
        longint unsigned lc, lp, l;
        res.cnt = hist[{row, col}];
        res.pk  = peak;
        l = 0;
        if (res.cnt != 0) begin
            lc = fixed_log2(64'(res.cnt) + 1);
            lp = fixed_log2(64'(peak) + 1);
            if (lp != 0) l = (255 * lc) / lp;
            if (l > 255) l = 255;
        end
        res.lum = l[7:0];
        return res;
    endfunction

    task automatic apply_to_model(t_stim s);
        logic [15:0] idx;
        case (s.op)
            agh_pkg::CMD_ADD: if (s.a != 0) begin
                idx = {s.a, grad_col(s.r, s.g, s.b)};
                if (hist[idx] != agh_pkg::COUNT_MAX) hist[idx] = hist[idx] + 1;
                if (hist[idx] > peak) peak = hist[idx];
            end
            agh_pkg::CMD_CLEAR: begin
                foreach (hist[i]) hist[i] = '0;
                peak = '0;
            end
            agh_pkg::CMD_READ: begin
                t_bin_read e;
                e = read_bin(s.row, s.col);
                if (s.known) begin
                    e.cnt = s.cnt;
                    e.pk  = s.pk;
                    e.lum = s.lum;
                end
                pending_reads.push_back(e);
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send(t_stim s);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= s.op;
        i_red      <= s.r;
        i_green    <= s.g;
        i_blue     <= s.b;
        i_alpha    <= s.a;
        i_read_row <= s.row;
        i_read_col <= s.col;
        apply_to_model(s);
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    function automatic t_stim mk(agh_pkg::t_cmd op, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] b, logic [7:0] a, logic [7:0] row,
                                 logic [7:0] col);
        t_stim s;
        s.op = op; s.r = r; s.g = g; s.b = b; s.a = a; s.row = row; s.col = col;
        s.known = 1'b0; s.cnt = '0; s.pk = '0; s.lum = '0;
        return s;
    endfunction

    function automatic t_stim mk_known(logic [7:0] row, logic [7:0] col, logic [23:0] c,
                                       logic [23:0] p, logic [7:0] l);
        t_stim s;
        s = mk(agh_pkg::CMD_READ, 0, 0, 0, 0, row, col);
        s.known = 1'b1; s.cnt = c; s.pk = p; s.lum = l;
        return s;
    endfunction

    // output checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (o_valid && !i_stall) begin
                if (pending_reads.size() == 0) begin
                    report("unexpected transfer", 1, 0);
                end else begin
                    t_bin_read e;
                    e = pending_reads.pop_front();
                    if (o_bin_count !== e.cnt) report("bin_count", o_bin_count, e.cnt);
                    if (o_peak_count !== e.pk) report("peak_count", o_peak_count, e.pk);
                    if (o_luminance !== e.lum) report("luminance", o_luminance, e.lum);
                end
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) i_stall <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(1, 4);
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_stim dir [$];
        t_stim s;
        int k;
        foreach (hist[i]) hist[i] = '0;
        peak = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        dir.push_back(mk_known(0, 0, 0, 0, 0));
        dir.push_back(mk_known(255, 255, 0, 0, 0));
        dir.push_back(mk(agh_pkg::CMD_ADD, 255, 255, 255, 255, 0, 0));   // column saturates
        dir.push_back(mk_known(255, 255, 1, 1, 255));
        dir.push_back(mk(agh_pkg::CMD_ADD, 0, 0, 0, 0, 0, 0));           // alpha zero skipped
        dir.push_back(mk(agh_pkg::CMD_ADD, 128, 127, 128, 1, 0, 0));
        dir.push_back(mk(agh_pkg::CMD_ADD, 128, 127, 128, 1, 0, 0));
        dir.push_back(mk(agh_pkg::CMD_ADD, 0, 255, 0, 1, 0, 0));
        dir.push_back(mk(agh_pkg::CMD_READ, 0, 0, 0, 0, 1, 1));
        dir.push_back(mk(agh_pkg::CMD_READ, 0, 0, 0, 0, 1, 255));
        dir.push_back(mk(agh_pkg::CMD_READ, 0, 0, 0, 0, 0, 1));
        dir.push_back(mk(agh_pkg::CMD_NONE, 255, 255, 255, 255, 255, 255));
        dir.push_back(mk(agh_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk_known(1, 1, 0, 0, 0));
        dir.push_back(mk(agh_pkg::CMD_ADD, 200, 10, 90, 170, 0, 0));
        dir.push_back(mk(agh_pkg::CMD_READ, 0, 0, 0, 0, 170, grad_col(200, 10, 90)));
        foreach (dir[i]) send(dir[i]);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n > N_RANDOM - 80) calm = 1'b1;
            k = $urandom_range(0, 99);
            if (k < 60) begin
                s = mk(agh_pkg::CMD_ADD, 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'd0, 8'd0);
                if (k < 35) begin   // concentrate on a few bins
                    s.a = 8'($urandom_range(1, 3));
                    s.r = 8'd128 + 8'($urandom_range(0, 1));
                    s.g = 8'd127;
                    s.b = 8'd128;
                end
                if (k == 59) s.a = 8'd0;
            end else if (k < 97) begin
                s = mk(agh_pkg::CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom));
                if (k < 85) begin
                    s.row = 8'($urandom_range(0, 3));
                    s.col = 8'($urandom_range(0, 2));
                end
            end else if (k < 99) begin
                s = mk(agh_pkg::CMD_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                s = mk(agh_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom));
            end
            send(s);
        end
        i_valid <= 1'b0;

        wait (pending_reads.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: sim.f
sv/agh_pkg.sv
sv/agh_front.sv
sv/agh_fifo.sv
sv/agh_log.sv
sv/agh_back.sv
sv/alpha_gradient_log_histogram.sv
sv/agh_checker.sv
verif/tb_alpha_gradient_log_histogram.sv
